[src/rhsv_pkg.sv]
// Shared types and constants for the RGB to HSV pixel converter.
`default_nettype none

package rhsv_pkg;

    localparam int PIX_W = 8;
    // quotient bits of each divider; two bits are resolved per stage
    localparam int QUO_W = 8;

    localparam logic [5:0]       HUE_SEXTANT   = 6'd42;
    localparam logic [PIX_W-1:0] HUE_OFF_RED   = 8'd0;
    localparam logic [PIX_W-1:0] HUE_OFF_GREEN = 8'd84;
    localparam logic [PIX_W-1:0] HUE_OFF_BLUE  = 8'd168;
    localparam logic [PIX_W-1:0] SAT_FULL      = 8'd255;

    typedef enum logic [1:0] {
        PICK_RED,
        PICK_GREEN,
        PICK_BLUE
    } pick_t;

    // after max/min selection
    typedef struct packed {
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] mn;
        pick_t            pick;
        logic             neg;
        logic [PIX_W-1:0] mag;
        logic [PIX_W-1:0] alpha;
    } sel_t;

    // side data that rides along the dividers
    typedef struct packed {
        pick_t            pick;
        logic             neg;
        logic             grey;
        logic             black;
        logic [PIX_W-1:0] bright;
        logic [PIX_W-1:0] alpha;
    } side_t;

endpackage

`default_nettype wire

[src/rgb_to_hsv_pixel_top.sv]
// A pixel passes through the selection stage, the dividend stage, the divider stages and the output stage.
// Throughput: one pixel per cycle while m_tready does not stall it; the two dividers resolve two bits per stage.
// The whole pipeline holds while a finished result waits on m_tready.
// Reset: aresetn clears every stage valid bit; payload registers are not reset.
`default_nettype none

module rgb_to_hsv_pixel_top #(
    parameter int QUO_W = rhsv_pkg::QUO_W
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red, green, blue, alpha
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // hue, saturation, brightness, alpha_out
);

    localparam int PW      = rhsv_pkg::PIX_W;
    localparam int DVW     = PW + QUO_W;
    localparam int DIV_LAT = QUO_W / 2;
    localparam int NV      = DIV_LAT + 3;

    logic          advance;
    logic [NV-1:0] v_reg;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign m_tvalid = v_reg[NV-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (advance) begin
            v_reg <= {v_reg[NV-2:0], s_tvalid};
        end
    end

    // stage 1: max with tie rules, min, signed hue numerator
    logic [PW-1:0] red, green, blue;
    rhsv_pkg::sel_t sel_next, sel_reg;
    logic [PW:0]    diff;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    always_comb begin
        sel_next = '0;
        if (red > green) begin
            sel_next.mx   = red;
            sel_next.pick = rhsv_pkg::PICK_RED;
        end else begin
            sel_next.mx   = green;
            sel_next.pick = rhsv_pkg::PICK_GREEN;
        end
        if (!(sel_next.mx > blue)) begin
            sel_next.mx   = blue;
            sel_next.pick = rhsv_pkg::PICK_BLUE;
        end
        sel_next.mn = (red < green) ? red : green;
        if (blue < sel_next.mn) begin
            sel_next.mn = blue;
        end
        unique case (sel_next.pick)
            rhsv_pkg::PICK_RED:   diff = {1'b0, green} - {1'b0, blue};
            rhsv_pkg::PICK_GREEN: diff = {1'b0, blue} - {1'b0, red};
            rhsv_pkg::PICK_BLUE:  diff = {1'b0, red} - {1'b0, green};
            default:              diff = '0;
        endcase
        sel_next.neg   = diff[PW];
        sel_next.mag   = diff[PW] ? PW'(~diff + 1'b1) : diff[PW-1:0];
        sel_next.alpha = s_tdata[31:24];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sel_reg <= sel_next;
        end
    end

    // stage 2: chroma and scaled dividends
    rhsv_pkg::side_t side_next;
    logic [PW-1:0]   chroma;
    logic [DVW-1:0]  hue_dvd_next, sat_dvd_next;
    logic [DVW-1:0]  hue_dvd_reg, sat_dvd_reg;
    logic [PW-1:0]   chroma_reg, mx_reg;
    rhsv_pkg::side_t side_reg [DIV_LAT+1];

    always_comb begin
        chroma       = sel_reg.mx - sel_reg.mn;
        hue_dvd_next = {{QUO_W{1'b0}}, sel_reg.mag} * DVW'(rhsv_pkg::HUE_SEXTANT);
        sat_dvd_next = DVW'({sel_reg.mn, 8'd0} - {8'd0, sel_reg.mn});
        side_next.pick   = sel_reg.pick;
        side_next.neg    = sel_reg.neg;
        side_next.grey   = (chroma == '0);
        side_next.black  = (sel_reg.mx == '0);
        side_next.bright = sel_reg.mx;
        side_next.alpha  = sel_reg.alpha;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hue_dvd_reg <= hue_dvd_next;
            sat_dvd_reg <= sat_dvd_next;
            chroma_reg  <= chroma;
            mx_reg      <= sel_reg.mx;
            side_reg[0] <= side_next;
            for (int i = 1; i <= DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // dividers
    logic [QUO_W-1:0] hue_quo, sat_quo;

    rhsv_div #(.QW(QUO_W), .DW(PW)) u_hue_div (
        .aclk     (aclk),
        .en       (advance),
        .dividend (hue_dvd_reg),
        .divisor  (chroma_reg),
        .quotient (hue_quo)
    );

    rhsv_div #(.QW(QUO_W), .DW(PW)) u_sat_div (
        .aclk     (aclk),
        .en       (advance),
        .dividend (sat_dvd_reg),
        .divisor  (mx_reg),
        .quotient (sat_quo)
    );

    // output stage: sign, offset, saturation complement
    rhsv_pkg::side_t sd;
    logic [PW-1:0]   hue_off, hue_term;
    logic [PW-1:0]   hue_next, sat_next;
    logic [PW-1:0]   hue_reg, sat_reg, bright_reg, alpha_reg;

    assign sd = side_reg[DIV_LAT];

    always_comb begin
        unique case (sd.pick)
            rhsv_pkg::PICK_RED:   hue_off = rhsv_pkg::HUE_OFF_RED;
            rhsv_pkg::PICK_GREEN: hue_off = rhsv_pkg::HUE_OFF_GREEN;
            rhsv_pkg::PICK_BLUE:  hue_off = rhsv_pkg::HUE_OFF_BLUE;
            default:              hue_off = rhsv_pkg::HUE_OFF_RED;
        endcase
        hue_term = sd.neg ? PW'(~hue_quo + 1'b1) : PW'(hue_quo);
        hue_next = sd.grey ? '0 : PW'(hue_off + hue_term);
        sat_next = sd.black ? '0 : PW'(rhsv_pkg::SAT_FULL - PW'(sat_quo));
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= sd.bright;
            alpha_reg  <= sd.alpha;
        end
    end

    assign m_tdata = {alpha_reg, bright_reg, sat_reg, hue_reg};

    // checks
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted transaction did not enter stage one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(v_reg))
        else $error("pipeline moved during a stall");

    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[23:16] == 8'd0) |-> (m_tdata[15:8] == 8'd0))
        else $error("black pixel with nonzero saturation");

endmodule

`default_nettype wire

[src/rhsv_div.sv]
// Pipelined restoring divider, two quotient bits per stage.
`default_nettype none

module rhsv_div #(
    parameter int QW = rhsv_pkg::QUO_W,
    parameter int DW = rhsv_pkg::PIX_W
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [DW+QW-1:0] dividend,   // must be below divisor * 2**QW
    input  wire logic [DW-1:0]    divisor,
    output logic      [QW-1:0]    quotient
);

    localparam int NS = QW / 2;
    localparam int RW = DW + QW;

    logic [RW-1:0] rem_reg [NS];
    logic [DW-1:0] dvs_reg [NS];
    logic [QW-1:0] quo_reg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int KH = QW - 1 - 2 * s;
        localparam int KL = KH - 1;

        logic [RW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [QW-1:0] q_in;
        logic [RW-1:0] dh;
        logic [RW-1:0] dl;
        logic [RW-1:0] r_mid;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] quo_next;
        logic          bh;
        logic          bl;

        if (s == 0) begin : g_first
            assign r_in = dividend;
            assign d_in = divisor;
            assign q_in = '0;
        end else begin : g_rest
            assign r_in = rem_reg[s-1];
            assign d_in = dvs_reg[s-1];
            assign q_in = quo_reg[s-1];
        end

        assign dh = {{QW{1'b0}}, d_in} << KH;
        assign dl = {{QW{1'b0}}, d_in} << KL;

        always_comb begin
            bh       = (r_in >= dh);
            r_mid    = bh ? (r_in - dh) : r_in;
            bl       = (r_mid >= dl);
            rem_next = bl ? (r_mid - dl) : r_mid;
            quo_next = q_in;
            quo_next[KH] = bh;
            quo_next[KL] = bl;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                dvs_reg[s] <= d_in;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign quotient = quo_reg[NS-1];

endmodule

`default_nettype wire

[tb/rgb_to_hsv_pixel_top_tb.sv]
// Self-checking testbench for rgb_to_hsv_pixel_top: directed and random pixels under random stalls.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_top_tb;

    localparam int SEXTANT    = int'(rhsv_pkg::HUE_SEXTANT);
    localparam int OFF_RED    = int'(rhsv_pkg::HUE_OFF_RED);
    localparam int OFF_GREEN  = int'(rhsv_pkg::HUE_OFF_GREEN);
    localparam int OFF_BLUE   = int'(rhsv_pkg::HUE_OFF_BLUE);
    localparam int FULL_SCALE = int'(rhsv_pkg::SAT_FULL);
    localparam int PROBE_N    = 22;
    localparam int RANDOM_N   = 1300;
    localparam int MAX_WAIT   = 17;
    localparam int DRAIN_CYC  = 3 + rhsv_pkg::QUO_W / 2 + 10;

    typedef struct packed {
        logic [rhsv_pkg::PIX_W-1:0] alpha_out;
        logic [rhsv_pkg::PIX_W-1:0] brightness;
        logic [rhsv_pkg::PIX_W-1:0] saturation;
        logic [rhsv_pkg::PIX_W-1:0] hue;
    } hsv_t;

    // pixel {alpha, blue, green, red}, whether hsv is typed in, hsv as hsv_t
    typedef struct packed {
        logic [31:0] pix;
        logic        known;
        logic [31:0] hsv;
    } probe_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    hsv_t pending_hsv[$];
    int   mismatches = 0;

    probe_t probes [PROBE_N] = '{
        {32'h00_00_00_00, 1'b1, 32'h00_00_00_00},   // black
        {32'hFF_FF_FF_FF, 1'b1, 32'hFF_FF_00_00},   // white
        {32'h80_00_00_FF, 1'b1, 32'h80_FF_FF_00},   // pure red
        {32'h01_00_FF_00, 1'b1, 32'h01_FF_FF_54},   // pure green
        {32'hFE_FF_00_00, 1'b1, 32'hFE_FF_FF_A8},   // pure blue
        {32'h55_64_00_C8, 1'b1, 32'h55_C8_FF_EB},   // red max, hue wraps to 235
        {32'hAA_00_64_64, 1'b1, 32'hAA_64_FF_2A},   // red/green tie goes to green
        {32'h00_64_32_64, 1'b1, 32'h00_64_80_D2},   // red/blue tie goes to blue
        {32'h7F_80_80_80, 1'b1, 32'h7F_80_00_00},   // mid grey
        {32'h00_00_00_01, 1'b1, 32'h00_01_FF_00},   // smallest nonzero max
        {32'h55_00_01_00, 1'b0, 32'h0},
        {32'hAA_01_00_00, 1'b0, 32'h0},
        {32'h0F_00_FE_FF, 1'b0, 32'h0},
        {32'hF0_FE_00_FF, 1'b0, 32'h0},
        {32'h33_FE_FF_00, 1'b0, 32'h0},
        {32'hCC_FF_FF_FE, 1'b0, 32'h0},
        {32'h5A_FF_00_FF, 1'b0, 32'h0},
        {32'hA5_01_01_01, 1'b0, 32'h0},
        {32'h12_AA_55_AA, 1'b0, 32'h0},
        {32'h34_55_AA_55, 1'b0, 32'h0},
        {32'h00_00_01_FF, 1'b0, 32'h0},
        {32'h00_FF_01_00, 1'b0, 32'h0}
    };

    rgb_to_hsv_pixel_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic hsv_t pixel_to_hsv(logic [31:0] pix);
        int              r, g, b, mx, mn, chroma, h, s;
        rhsv_pkg::pick_t pick;
        hsv_t            res;
        r = int'(pix[7:0]);
        g = int'(pix[15:8]);
        b = int'(pix[23:16]);
        if (r > g) begin
            mx = r;
            pick = rhsv_pkg::PICK_RED;
        end else begin
            mx = g;
            pick = rhsv_pkg::PICK_GREEN;
        end
        if (!(mx > b)) begin
            mx = b;
            pick = rhsv_pkg::PICK_BLUE;
        end
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        chroma = mx - mn;
        h = 0;
        if (chroma != 0) begin
            case (pick)
                rhsv_pkg::PICK_RED:   h = ((g - b) * SEXTANT) / chroma + OFF_RED;
                rhsv_pkg::PICK_GREEN: h = ((b - r) * SEXTANT) / chroma + OFF_GREEN;
                default:              h = ((r - g) * SEXTANT) / chroma + OFF_BLUE;
            endcase
        end
        s = (mx != 0) ? FULL_SCALE - (mn * FULL_SCALE) / mx : 0;
        res.hue        = h[7:0];
        res.saturation = s[7:0];
        res.brightness = mx[7:0];
        res.alpha_out  = pix[31:24];
        return res;
    endfunction

    // Alternate stretches of random waits with stretches of back-to-back transactions.
    task automatic draw_wait(inout int run_left, inout bit calm, output int n);
        if (run_left == 0) begin
            run_left = $urandom_range(20, 80);
            calm = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        n = calm ? 0 : $urandom_range(0, MAX_WAIT);
    endtask

    function automatic logic [7:0] near(int base);
        int v;
        v = base + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic logic [7:0] edge_val();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            3: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] random_pixel();
        logic [7:0] r, g, b, a;
        int base;
        a = 8'($urandom_range(0, 255));
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: begin
                base = $urandom_range(0, 255);
                r = near(base);
                g = near(base);
                b = near(base);
            end
            1: g = r;
            2: b = (g > r) ? g : r;
            3: begin
                r = edge_val();
                g = edge_val();
                b = edge_val();
            end
            default: ;
        endcase
        return {a, b, g, r};
    endfunction

    task automatic drive_pixel(logic [31:0] pix, int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Scoreboard: predict on input transactions, compare on output transactions.
    always @(posedge aclk) begin
        hsv_t want, got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_hsv.push_back(pixel_to_hsv(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_hsv.size() == 0) begin
                    $display("%0t: result expected none actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_hsv.pop_front();
                    if (got.hue !== want.hue) begin
                        $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
                        mismatches++;
                    end
                    if (got.saturation !== want.saturation) begin
                        $display("%0t: saturation expected %0d actual %0d",
                                 $time, want.saturation, got.saturation);
                        mismatches++;
                    end
                    if (got.brightness !== want.brightness) begin
                        $display("%0t: brightness expected %0d actual %0d",
                                 $time, want.brightness, got.brightness);
                        mismatches++;
                    end
                    if (got.alpha_out !== want.alpha_out) begin
                        $display("%0t: alpha_out expected %0d actual %0d",
                                 $time, want.alpha_out, got.alpha_out);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result side: hold tready low for a drawn number of cycles before each transaction.
    initial begin
        int run_left, n;
        bit calm;
        run_left = 0;
        calm = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            draw_wait(run_left, calm, n);
            @(negedge aclk);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int run_left, n;
        bit calm;
        hsv_t want;
        run_left = 0;
        calm = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 32'h0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PROBE_N; i++) begin
            // typed-in rows must also agree with the predictor
            if (probes[i].known) begin
                want = pixel_to_hsv(probes[i].pix);
                if (want !== hsv_t'(probes[i].hsv)) begin
                    $display("%0t: pixel %h expected %h actual %h", $time,
                             probes[i].pix, probes[i].hsv, want);
                    mismatches++;
                end
            end
            draw_wait(run_left, calm, n);
            drive_pixel(probes[i].pix, n);
        end

        for (int i = 0; i < RANDOM_N; i++) begin
            draw_wait(run_left, calm, n);
            drive_pixel(random_pixel(), n);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_hsv.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
